// ----- sv/alra_pkg.sv -----
`default_nettype none
package alra_pkg;
  localparam int NUM_POOLS = 3;
  localparam logic [15:0] NO_OWNER = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_COMMIT = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_LIFETIME = 2'd0,
    REG_LAYERED  = 2'd1,
    REG_SINGLE   = 2'd2,
    REG_CUBE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  pool;
    logic [15:0] light_id;
    logic        has_offset;
    logic [5:0]  cur_offset;
    logic [2:0]  layer_count;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [5:0]  new_offset;
    logic [15:0] pass_index;
  } rsp_t;
endpackage
`default_nettype wire

// ----- sv/alra_if.sv -----
`default_nettype none
interface alra_req_if import alra_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface alra_rsp_if import alra_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface alra_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ----- sv/alra_slot_mem.sv -----
`default_nettype none
// Slot store: age and owner per slot, one read and one write port, registered read.
module alra_slot_mem #(
  parameter int DEPTH = 192,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rage,
  output logic [15:0]        rowner,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wage,
  input  wire logic [15:0]   wowner
);
  logic [23:0] mem [DEPTH];
  logic [23:0] rd_r;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wage, wowner};
    rd_r <= mem[raddr];
  end
  assign rage   = rd_r[23:16];
  assign rowner = rd_r[15:0];
endmodule
`default_nettype wire

// ----- sv/aging_layer_range_allocator_top.sv -----
`default_nettype none
// Steps per request: tick reads then writes back every slot of all pools; free releases
//   the range; rejected or rangeless requests finish directly; commit runs renewal, then on
//   a broken range release, search (window scan, moving on after a miss), and claim.
// Throughput: one request at a time; the next is taken only after the result is accepted.
// Reset: synchronous active-low; clears registers, then sweeps all 3*SLOTS_PER_POOL
//   slots to free/no owner before taking requests.
module aging_layer_range_allocator_top import alra_pkg::*; #(
  parameter int SLOTS_PER_POOL = 64,
  parameter int MAX_RUN = 4
) (
  input wire logic clk,
  input wire logic rst_n,
  alra_req_if.sink   in_req,
  alra_rsp_if.source out_rsp,
  alra_cfg_if.sink   cfg_wr
);
  localparam int DEPTH = NUM_POOLS * SLOTS_PER_POOL;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(SLOTS_PER_POOL + 1);  // slot index incl. size
  localparam int CW = $clog2(MAX_RUN + 1) + 1;

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_TICKR = 9'b000000100,  // read issued, data next
    S_TICKW = 9'b000001000,
    S_RENR  = 9'b000010000,  // renewal check
    S_RELR  = 9'b000100000,  // release range (free or broken renewal)
    S_SRCH  = 9'b001000000,  // window scan
    S_CLAIM = 9'b010000000,
    S_DONE  = 9'b100000000
  } st_t;

  st_t state_r, state_nxt;
  req_t req_r;
  logic [7:0] life_r;
  logic [6:0] psize_r [NUM_POOLS];
  logic [15:0] pass_r [NUM_POOLS];
  logic [AW-1:0] addr_r;      // sweep address (clear, tick)
  logic [SW-1:0] win_r;       // search window start
  logic [CW-1:0] k_r;         // position within run
  logic phase_r;              // 0: read issued, 1: data valid
  logic ren_ok_r;
  logic rsp_valid_r;
  rsp_t rsp_r;

  logic [AW-1:0] raddr, waddr;
  logic [7:0] rage, wage;
  logic [15:0] rowner, wowner;
  logic we;

  alra_slot_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk, .raddr, .rage, .rowner, .we, .waddr, .wage, .wowner
  );

  // effective pool size, clipped to SLOTS_PER_POOL
  logic [SW-1:0] size;
  logic [1:0] pidx;
  assign pidx = (req_r.pool < 2'(NUM_POOLS)) ? req_r.pool : 2'd0;
  always_comb begin
    if (32'(psize_r[pidx]) > SLOTS_PER_POOL) size = SW'(SLOTS_PER_POOL);
    else size = SW'(psize_r[pidx]);
  end

  logic [AW-1:0] base;
  assign base = AW'(32'(pidx) * SLOTS_PER_POOL);
  logic [SW:0] cur_k, win_k;
  assign cur_k = (SW+1)'(req_r.cur_offset) + (SW+1)'(k_r);
  assign win_k = (SW+1)'(win_r) + (SW+1)'(k_r);
  logic [CW-1:0] cnt;
  assign cnt = CW'(req_r.layer_count);
  logic cur_in;
  assign cur_in = cur_k < (SW+1)'(size);

  logic in_fire, out_fire, cfg_fire;
  assign in_req.ready = (state_r == S_IDLE) && !rsp_valid_r;
  assign in_fire = in_req.valid && in_req.ready;
  assign out_fire = rsp_valid_r && out_rsp.ready;
  assign out_rsp.valid = rsp_valid_r;
  assign out_rsp.data = rsp_r;
  // registers change only between requests, never during the clear sweep
  assign cfg_wr.ready = (state_r == S_IDLE);
  assign cfg_fire = cfg_wr.valid && cfg_wr.ready;

  logic finish;
  rsp_t fin_rsp;
  logic pass_inc, pass_clr;

  always_comb begin
    state_nxt = state_r;
    raddr = addr_r;
    we = 1'b0;
    waddr = addr_r;
    wage = life_r;
    wowner = NO_OWNER;
    finish = 1'b0;
    fin_rsp = '0;
    pass_inc = 1'b0;
    pass_clr = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        if (32'(addr_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_req.data.func)
            FUNC_TICK: state_nxt = S_TICKR;
            FUNC_FREE: begin
              if (in_req.data.pool < 2'(NUM_POOLS) &&
                  32'(in_req.data.layer_count) <= MAX_RUN) begin
                state_nxt = in_req.data.has_offset ? S_RELR : S_DONE;
              end else begin
                state_nxt = S_DONE;
              end
            end
            FUNC_COMMIT: begin
              if (in_req.data.pool < 2'(NUM_POOLS) && in_req.data.layer_count != 3'd0 &&
                  32'(in_req.data.layer_count) <= MAX_RUN &&
                  in_req.data.light_id != NO_OWNER) begin
                state_nxt = in_req.data.has_offset ? S_RENR : S_SRCH;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_TICKR: state_nxt = S_TICKW;
      S_TICKW: begin
        // read of addr_r issued last cycle, data now valid
        raddr = addr_r;
        we = rage < life_r;
        wage = rage + 8'd1;
        wowner = rowner;
        if (32'(addr_r) == DEPTH - 1) begin
          pass_clr = 1'b1;
          finish = 1'b1;
          fin_rsp.success = 1'b1;
        end else begin
          state_nxt = S_TICKR;
        end
      end
      S_RENR: begin
        raddr = base + AW'(cur_k);
        waddr = raddr;
        if (phase_r && cur_in && rowner == req_r.light_id) begin
          we = 1'b1;
          wage = 8'd0;
          wowner = rowner;
        end
        if (phase_r && k_r == cnt - CW'(1)) begin
          if (ren_ok_r && cur_in && rowner == req_r.light_id) begin
            pass_inc = 1'b1;
            finish = 1'b1;
            fin_rsp.success = 1'b1;
            fin_rsp.new_offset = req_r.cur_offset;
            fin_rsp.pass_index = pass_r[pidx];
          end else begin
            state_nxt = S_RELR;
          end
        end
      end
      S_RELR: begin
        waddr = base + AW'(cur_k);
        we = cur_in && (k_r < cnt);
        if (k_r >= cnt) begin
          if (req_r.func == FUNC_FREE) begin
            finish = 1'b1;
            fin_rsp.success = 1'b1;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        raddr = base + AW'(win_k);
        if ((SW+1)'(win_r) + (SW+1)'(cnt) > (SW+1)'(size)) begin
          finish = 1'b1;
        end else if (phase_r && k_r == cnt - CW'(1) && rage >= life_r) begin
          state_nxt = S_CLAIM;
        end
      end
      S_CLAIM: begin
        waddr = base + AW'(win_k);
        we = k_r < cnt;
        wage = 8'd0;
        wowner = req_r.light_id;
        if (k_r >= cnt) begin
          pass_inc = 1'b1;
          finish = 1'b1;
          fin_rsp.success = 1'b1;
          fin_rsp.new_offset = 6'(win_r);
          fin_rsp.pass_index = pass_r[pidx];
        end
      end
      S_DONE: begin
        finish = 1'b1;
        fin_rsp.success = (req_r.func == FUNC_FREE) && (req_r.pool < 2'(NUM_POOLS)) &&
                          (32'(req_r.layer_count) <= MAX_RUN);
      end
      default: state_nxt = S_IDLE;
    endcase
    if (finish) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r <= '0;
      life_r <= 8'd4;
      for (int p = 0; p < NUM_POOLS; p++) begin
        psize_r[p] <= 7'd16;
        pass_r[p] <= '0;
      end
      rsp_valid_r <= 1'b0;
      win_r <= '0;
      k_r <= '0;
      phase_r <= 1'b0;
      ren_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_wr.index)
          REG_LIFETIME: life_r <= cfg_wr.wdata;
          REG_LAYERED:  psize_r[0] <= cfg_wr.wdata[6:0];
          REG_SINGLE:   psize_r[1] <= cfg_wr.wdata[6:0];
          REG_CUBE:     psize_r[2] <= cfg_wr.wdata[6:0];
          default: ;
        endcase
      end
      if (finish) rsp_valid_r <= 1'b1;
      else if (out_fire) rsp_valid_r <= 1'b0;
      if (pass_clr) for (int p = 0; p < NUM_POOLS; p++) pass_r[p] <= '0;
      if (pass_inc) pass_r[pidx] <= pass_r[pidx] + 16'd1;
      case (state_r)
        S_CLEAR: addr_r <= (32'(addr_r) == DEPTH - 1) ? '0 : addr_r + AW'(1);
        S_IDLE: begin
          addr_r <= '0;
          win_r <= '0;
          k_r <= '0;
          phase_r <= 1'b0;
          ren_ok_r <= 1'b1;
        end
        S_TICKW: addr_r <= (32'(addr_r) == DEPTH - 1) ? '0 : addr_r + AW'(1);
        S_RENR: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            if (!(cur_in && rowner == req_r.light_id)) ren_ok_r <= 1'b0;
            k_r <= (k_r == cnt - CW'(1)) ? '0 : k_r + CW'(1);
          end
        end
        S_RELR: k_r <= (k_r >= cnt) ? '0 : k_r + CW'(1);
        S_SRCH: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            if (rage < life_r) begin
              win_r <= win_r + SW'(1);
              k_r <= '0;
            end else if (k_r != cnt - CW'(1)) begin
              k_r <= k_r + CW'(1);
            end else begin
              k_r <= '0;
            end
          end
        end
        S_CLAIM: k_r <= k_r + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_req.data;
    if (finish) rsp_r <= fin_rsp;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE) else $error("request taken while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !rsp_valid_r || out_fire) else $error("result overwritten");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid_r && !rsp_r.success |-> rsp_r.new_offset == 6'd0 && rsp_r.pass_index == 16'd0)
    else $error("failed result carries data");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alra_pkg::*;

  localparam int SLOTS     = 64;
  localparam int RUN_MAX   = 4;
  localparam int TOT_SLOTS = NUM_POOLS * SLOTS;
  // Cycle limit for the whole run; reaching it ends the test as failed.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int N_OWNERS = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  alra_req_if in_req ();
  alra_rsp_if out_rsp ();
  alra_cfg_if cfg ();

  aging_layer_range_allocator_top #(.SLOTS_PER_POOL(SLOTS), .MAX_RUN(RUN_MAX)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the allocator: slot ages/owners, pass counters, registers.
  bit [7:0]  shadow_age [TOT_SLOTS];
  bit [15:0] shadow_owner [TOT_SLOTS];
  bit [15:0] shadow_pass [NUM_POOLS];
  bit [7:0]  shadow_life;
  bit [6:0]  shadow_psize [NUM_POOLS];

  rsp_t pending_results[$];
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  // Owner table for random traffic, so renewals actually hit held ranges.
  bit [15:0] own_id [N_OWNERS];
  bit [1:0]  own_pool [N_OWNERS];
  bit        own_held [N_OWNERS];
  bit [5:0]  own_ofs [N_OWNERS];
  bit [2:0]  own_cnt [N_OWNERS];

  function automatic int eff_size(int p);
    return (shadow_psize[p] > SLOTS) ? SLOTS : int'(shadow_psize[p]);
  endfunction

  // Release slots of a range that lie inside the pool; the rest are skipped.
  function automatic void drop_range(int p, int first, int cnt, int sz);
    int s;
    for (int i = 0; i < cnt; i++) begin
      s = first + i;
      if (s < sz) begin
        shadow_age[p*SLOTS + s]   = shadow_life;
        shadow_owner[p*SLOTS + s] = NO_OWNER;
      end
    end
  endfunction

  function automatic rsp_t predict_alloc_result(req_t r);
    rsp_t res;
    int   p, cnt, cur, sz, base;
    bit   done, held_all, fits;
    res  = '0;
    p    = r.pool;
    cnt  = r.layer_count;
    cur  = r.cur_offset;
    done = 1'b0;
    case (func_t'(r.func))
      FUNC_TICK: begin
        for (int i = 0; i < NUM_POOLS; i++) shadow_pass[i] = '0;
        for (int i = 0; i < TOT_SLOTS; i++)
          if (shadow_age[i] < shadow_life) shadow_age[i]++;
        res.success = 1'b1;
      end
      FUNC_FREE: begin
        if (p < NUM_POOLS && cnt <= RUN_MAX) begin
          if (r.has_offset) drop_range(p, cur, cnt, eff_size(p));
          res.success = 1'b1;
        end
      end
      FUNC_COMMIT: begin
        if (p < NUM_POOLS && cnt != 0 && cnt <= RUN_MAX && r.light_id != NO_OWNER) begin
          sz   = eff_size(p);
          base = p * SLOTS;
          if (r.has_offset) begin
            // renewal: refresh owned slots, any miss breaks the range
            held_all = 1'b1;
            for (int i = 0; i < cnt; i++) begin
              if (cur + i < sz && shadow_owner[base + cur + i] == r.light_id)
                shadow_age[base + cur + i] = '0;
              else
                held_all = 1'b0;
            end
            if (held_all) begin
              done = 1'b1;
              res.new_offset = cur[5:0];
            end else begin
              drop_range(p, cur, cnt, sz);
            end
          end
          if (!done && cnt <= sz) begin
            // first fit, last offset included
            for (int i = 0; i + cnt <= sz && !done; i++) begin
              fits = 1'b1;
              for (int j = i; j < i + cnt; j++)
                if (shadow_age[base + j] < shadow_life) fits = 1'b0;
              if (fits) begin
                for (int j = i; j < i + cnt; j++) begin
                  shadow_age[base + j]   = '0;
                  shadow_owner[base + j] = r.light_id;
                end
                res.new_offset = i[5:0];
                done = 1'b1;
              end
            end
          end
          if (done) begin
            res.success    = 1'b1;
            res.pass_index = shadow_pass[p];
            shadow_pass[p] = shadow_pass[p] + 16'd1;
          end else begin
            res.new_offset = '0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sender: raise valid, hold until the request is taken, then predict.
  task automatic send_req(input req_t r, output rsp_t predicted);
    if (send_idle_pct > 0) begin
      in_req.valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= r;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    predicted = predict_alloc_result(r);
    pending_results = {pending_results, predicted};
  endtask

  task automatic send_only(input req_t r);
    rsp_t dummy;
    send_req(r, dummy);
  endtask

  // Hold off until every outstanding result has come back.
  task automatic wait_idle();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input bit [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_LIFETIME) shadow_life = val;
    else shadow_psize[int'(idx) - 1] = val[6:0];
  endtask

  task automatic set_regs(bit [7:0] life, bit [7:0] s0, bit [7:0] s1, bit [7:0] s2);
    wait_idle();
    write_reg(REG_LIFETIME, life);
    write_reg(REG_LAYERED, s0);
    write_reg(REG_SINGLE, s1);
    write_reg(REG_CUBE, s2);
  endtask

  function automatic req_t mk(func_t f, int p, int id, bit ho, int ofs, int cnt);
    req_t r;
    r.func        = f;
    r.pool        = p[1:0];
    r.light_id    = id[15:0];
    r.has_offset  = ho;
    r.cur_offset  = ofs[5:0];
    r.layer_count = cnt[2:0];
    return r;
  endfunction

  // Result checker: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %p", out_rsp.data);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.data.success !== want.success ||
            out_rsp.data.new_offset !== want.new_offset ||
            out_rsp.data.pass_index !== want.pass_index) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp ok=%0d ofs=%0d pidx=%0d got ok=%0d ofs=%0d pidx=%0d",
                     want.success, want.new_offset, want.pass_index,
                     out_rsp.data.success, out_rsp.data.new_offset,
                     out_rsp.data.pass_index);
        end
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    out_rsp.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Extremes of every field, each op, and the corner cases marked below.
  task automatic test_directed();
    rsp_t r;
    send_only(mk(FUNC_TICK, 0, 0, 0, 0, 0));
    send_only(mk(FUNC_COMMIT, 0, 1, 0, 0, 1));
    send_only(mk(FUNC_COMMIT, 0, 2, 0, 0, 4));
    send_only(mk(FUNC_COMMIT, 0, 1, 1, 0, 1));         // clean renewal
    send_only(mk(FUNC_COMMIT, 0, 3, 1, 1, 2));         // broken renewal, frees
    send_only(mk(FUNC_COMMIT, 1, 4, 1, 63, 4));        // range beyond pool size
    send_only(mk(FUNC_COMMIT, 1, 5, 0, 0, 0));         // zero count
    send_only(mk(FUNC_COMMIT, 1, 5, 0, 0, 5));         // count too big
    send_only(mk(FUNC_COMMIT, 1, 5, 0, 0, 7));
    send_only(mk(FUNC_COMMIT, 2, 65535, 0, 0, 2));     // reserved id
    send_only(mk(FUNC_COMMIT, 3, 6, 0, 0, 2));         // bad pool
    send_only(mk(FUNC_FREE, 3, 6, 1, 0, 2));
    send_only(mk(FUNC_NONE, 0, 6, 1, 0, 2));           // undefined func
    send_only(mk(FUNC_FREE, 0, 2, 0, 1, 4));           // no range held
    send_only(mk(FUNC_FREE, 0, 2, 1, 1, 4));
    send_only(mk(FUNC_FREE, 0, 2, 1, 1, 6));
    send_only(mk(FUNC_FREE, 2, 7, 1, 62, 4));          // entirely out of pool
    send_only(mk(FUNC_COMMIT, 2, 65534, 0, 0, 4));
    send_only(mk(FUNC_TICK, 3, 65535, 1, 63, 7));
    // zero lifetime, empty and oversize pools
    set_regs(8'd0, 8'd0, 8'd64, 8'd127);
    send_only(mk(FUNC_COMMIT, 0, 9, 0, 0, 1));         // empty pool fails
    send_only(mk(FUNC_COMMIT, 1, 9, 0, 0, 4));
    send_only(mk(FUNC_COMMIT, 1, 10, 0, 0, 4));        // all free at life 0
    send_only(mk(FUNC_COMMIT, 2, 11, 1, 61, 3));
    send_only(mk(FUNC_TICK, 0, 0, 0, 0, 0));
    set_regs(8'd255, 8'd64, 8'd1, 8'd4);
    send_req(mk(FUNC_COMMIT, 1, 12, 0, 0, 1), r);
    send_only(mk(FUNC_COMMIT, 1, 13, 0, 0, 1));        // pool full
  endtask

  function automatic req_t random_req();
    req_t r;
    int   k, sel;
    sel = $urandom_range(99);
    k   = $urandom_range(N_OWNERS - 1);
    if (sel < 10) begin
      r = mk(FUNC_TICK, $urandom_range(3), $urandom_range(65535), $urandom_range(1),
             $urandom_range(63), $urandom_range(7));
    end else if (sel < 70) begin
      // well-formed commit from a tracked owner
      r = mk(FUNC_COMMIT, own_pool[k], own_id[k], own_held[k], own_ofs[k], own_cnt[k]);
      if ($urandom_range(9) == 0) r.layer_count = $urandom_range(1, RUN_MAX);
    end else if (sel < 85) begin
      r = mk(FUNC_FREE, own_pool[k], own_id[k], own_held[k], own_ofs[k], own_cnt[k]);
    end else begin
      // noise across the whole field space
      r = mk(func_t'($urandom_range(3)), $urandom_range(3), $urandom_range(65535),
             $urandom_range(1), $urandom_range(63), $urandom_range(7));
    end
    return r;
  endfunction

  task automatic test_random(int n, int idle_pct, int stall_pct);
    req_t r;
    rsp_t res;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < N_OWNERS; i++) begin
      own_id[i]   = (i == 0) ? 16'hFFFE : 16'($urandom_range(65534));
      own_pool[i] = $urandom_range(NUM_POOLS - 1);
      own_held[i] = 1'b0;
      own_ofs[i]  = '0;
      own_cnt[i]  = $urandom_range(1, RUN_MAX);
    end
    for (int n_sent = 0; n_sent < n; n_sent++) begin
      r = random_req();
      send_req(r, res);
      for (int k = 0; k < N_OWNERS; k++) begin
        if (r.light_id == own_id[k] && r.pool == own_pool[k]) begin
          if (r.func == FUNC_COMMIT && r.layer_count == own_cnt[k]) begin
            own_held[k] = res.success;
            own_ofs[k]  = res.new_offset;
          end else if (r.func == FUNC_FREE && res.success) begin
            own_held[k] = 1'b0;
            own_cnt[k]  = $urandom_range(1, RUN_MAX);
          end
        end
      end
      if (n_sent == n / 2) wait_idle();   // drain fully once mid-phase
    end
  endtask

  initial begin
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    cfg.valid     = 1'b0;
    cfg.index     = REG_LIFETIME;
    cfg.wdata     = '0;
    out_rsp.ready = 1'b0;
    shadow_life = 8'd4;
    for (int i = 0; i < NUM_POOLS; i++) begin
      shadow_psize[i] = 7'd16;
      shadow_pass[i]  = '0;
    end
    for (int i = 0; i < TOT_SLOTS; i++) begin
      shadow_age[i]   = 8'd4;
      shadow_owner[i] = NO_OWNER;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    set_regs(8'd3, 8'd12, 8'd8, 8'd16);
    test_random(400, 0, 0);
    set_regs(8'd1, 8'd6, 8'd64, 8'd9);
    test_random(400, 83, 0);
    set_regs(8'd2, 8'd100, 8'd5, 8'd10);       // raised lifetime, oversize pool
    test_random(400, 0, 83);
    set_regs(8'd255, 8'd8, 8'd7, 8'd0);
    test_random(400, 25, 25);

    wait_idle();
    repeat (400) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/alra_pkg.sv
sv/alra_if.sv
sv/alra_slot_mem.sv
sv/aging_layer_range_allocator_top.sv
tb/sv/tb.sv
